### rtl/core/pens_pkg.sv
// Shared constants, types and codes for the pure-strategy epsilon-Nash search block.
// Used by pure_epsilon_nash_search and the testbench; depends on nothing else.
package pens_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int MAX_COLS  = 16;
    localparam int FRAC_BITS = 16;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PAY_W  = FRAC_BITS + 1;
    localparam int DIM_W  = 5;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [PAY_W-1:0] ONE_FX = PAY_W'(1) << FRAC_BITS;

    // Register index codes, taken from paddr[2].
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    // Input function codes.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PASS1  = 5'b00010,
        ST_PASS2  = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } pens_state_t;

endpackage

### rtl/core/pens_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Has no dependencies.
module pens_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/pure_epsilon_nash_search.sv
// Top level of the pure-strategy epsilon-Nash search: APB registers, payoff memories,
// two-pass search sequencer and output register. Depends on pens_pkg and pens_ram.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------------------
//   in       | in_valid / in_stall       | func, row_index, col_index, row_payoff, col_payoff
//   out      | out_valid / out_stall     | best_row, best_col, regret
//   config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// Loads can be taken back to back. A search item makes two passes over the R rows
// and C columns in use, with one read of the payoff memories per cell in each pass.
// Reset clears the configuration, the sequencer, the running best and out_valid;
// the payoff memories, the column and row maxima and the output data are not cleared.
// While a search runs, in_stall is high. A finished result waits in the output
// register, and the next load or search is taken while it waits.
module pure_epsilon_nash_search
    import pens_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [3:0]          row_index,
    input  logic [3:0]          col_index,
    input  logic [16:0]         row_payoff,
    input  logic [16:0]         col_payoff,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          best_row,
    output logic [3:0]          best_col,
    output logic [16:0]         regret,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // Configuration registers.
    logic [DIM_W-1:0] num_rows_reg;
    logic [DIM_W-1:0] num_cols_reg;
    logic             cfg_write;

    // Effective dimensions after clamping.
    logic [ROW_W:0]   rows_eff;
    logic [COL_W:0]   cols_eff;

    // Sequencer.
    pens_state_t      state_reg, state_next;
    logic [ROW_W-1:0] r_reg, r_next;
    logic [COL_W-1:0] c_reg, c_next;
    logic             last_cell;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Memory read stage.
    logic             s1_valid_reg;
    logic             s1_pass2_reg;
    logic [ROW_W-1:0] s1_r_reg;
    logic [COL_W-1:0] s1_c_reg;
    logic [PAY_W-1:0] row_rd_data;
    logic [PAY_W-1:0] col_rd_data;

    // Regret stage.
    logic             s2_valid_reg;
    logic [ROW_W-1:0] s2_r_reg;
    logic [COL_W-1:0] s2_c_reg;
    logic [PAY_W-1:0] s2_regret_reg;
    logic [PAY_W-1:0] gap_row;
    logic [PAY_W-1:0] gap_col;
    logic [PAY_W-1:0] cell_regret;

    // Per-column maximum of row payoffs and per-row maximum of column payoffs.
    logic [PAY_W-1:0] colmax_reg [MAX_COLS];
    logic [PAY_W-1:0] rowmax_reg [MAX_ROWS];

    // Running best.
    logic [PAY_W-1:0] best_regret_reg;
    logic [ROW_W-1:0] best_r_reg;
    logic [COL_W-1:0] best_c_reg;

    // Output register.
    logic             out_valid_reg;
    logic [3:0]       out_row_reg;
    logic [3:0]       out_col_reg;
    logic [16:0]      out_regret_reg;

    logic             in_accept;
    logic             load_wr;
    logic             search_start;
    logic             out_load;
    logic [ADDR_W-1:0] wr_addr;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= DIM_W'(1);
            num_cols_reg <= DIM_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_NUM_ROWS: num_rows_reg <= pwdata[DIM_W-1:0];
                REG_NUM_COLS: num_cols_reg <= pwdata[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_NUM_ROWS: prdata = APB_DW'(num_rows_reg);
            REG_NUM_COLS: prdata = APB_DW'(num_cols_reg);
            default:      prdata = '0;
        endcase
    end

    // A dimension of zero counts as one; any value above the maximum counts as the maximum.
    always_comb
    begin
        if (num_rows_reg == '0)
            rows_eff = (ROW_W+1)'(1);
        else if (int'(num_rows_reg) > MAX_ROWS)
            rows_eff = (ROW_W+1)'(MAX_ROWS);
        else
            rows_eff = (ROW_W+1)'(num_rows_reg);

        if (num_cols_reg == '0)
            cols_eff = (COL_W+1)'(1);
        else if (int'(num_cols_reg) > MAX_COLS)
            cols_eff = (COL_W+1)'(MAX_COLS);
        else
            cols_eff = (COL_W+1)'(num_cols_reg);
    end

    // ---------------- input side ----------------
    assign in_stall     = (state_reg != ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign load_wr      = in_accept && (func == FUNC_LOAD)
                          && (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_COLS);
    assign search_start = in_accept && (func == FUNC_SEARCH);
    assign wr_addr      = ADDR_W'(int'(row_index) * MAX_COLS + int'(col_index));

    // ---------------- payoff memories ----------------
    assign rd_en   = (state_reg == ST_PASS1) || (state_reg == ST_PASS2);
    assign rd_addr = ADDR_W'(int'(r_reg) * MAX_COLS + int'(c_reg));

    pens_ram #(
        .WIDTH (PAY_W),
        .DEPTH (CELLS)
    ) u_row_mem (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (wr_addr),
        .wr_data (PAY_W'(row_payoff)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (row_rd_data)
    );

    pens_ram #(
        .WIDTH (PAY_W),
        .DEPTH (CELLS)
    ) u_col_mem (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (wr_addr),
        .wr_data (PAY_W'(col_payoff)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (col_rd_data)
    );

    // ---------------- sequencer ----------------
    assign last_cell = ({1'b0, r_reg} == rows_eff - (ROW_W+1)'(1))
                       && ({1'b0, c_reg} == cols_eff - (COL_W+1)'(1));
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        if (rd_en)
        begin
            if ({1'b0, c_reg} == cols_eff - (COL_W+1)'(1))
            begin
                c_next = '0;
                r_next = r_reg + ROW_W'(1);
            end
            else
            begin
                c_next = c_reg + COL_W'(1);
            end
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                r_next = '0;
                c_next = '0;
                if (search_start)
                    state_next = ST_PASS1;
            end
            ST_PASS1:
            begin
                if (last_cell)
                begin
                    r_next     = '0;
                    c_next     = '0;
                    state_next = ST_PASS2;
                end
            end
            ST_PASS2:
            begin
                if (last_cell)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            r_reg        <= '0;
            c_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            s1_valid_reg <= rd_en;
            s2_valid_reg <= s1_valid_reg && s1_pass2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pass2_reg <= (state_reg == ST_PASS2);
        s1_r_reg     <= r_reg;
        s1_c_reg     <= c_reg;
    end

    // ---------------- first pass: row and column maxima ----------------
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && !s1_pass2_reg)
        begin
            if (s1_r_reg == '0 || row_rd_data > colmax_reg[s1_c_reg])
                colmax_reg[s1_c_reg] <= row_rd_data;
            if (s1_c_reg == '0 || col_rd_data > rowmax_reg[s1_r_reg])
                rowmax_reg[s1_r_reg] <= col_rd_data;
        end
    end

    // ---------------- second pass: regret and running minimum ----------------
    // The maxima include the cell itself, so neither gap can go negative.
    assign gap_row     = colmax_reg[s1_c_reg] - row_rd_data;
    assign gap_col     = rowmax_reg[s1_r_reg] - col_rd_data;
    assign cell_regret = (gap_row > gap_col) ? gap_row : gap_col;

    always_ff @(posedge clk)
    begin
        s2_r_reg      <= s1_r_reg;
        s2_c_reg      <= s1_c_reg;
        s2_regret_reg <= cell_regret;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_regret_reg <= ONE_FX;
            best_r_reg      <= '0;
            best_c_reg      <= '0;
        end
        else if (search_start)
        begin
            best_regret_reg <= ONE_FX;
            best_r_reg      <= '0;
            best_c_reg      <= '0;
        end
        else if (s2_valid_reg && (s2_regret_reg < best_regret_reg))
        begin
            best_regret_reg <= s2_regret_reg;
            best_r_reg      <= s2_r_reg;
            best_c_reg      <= s2_c_reg;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg    <= 4'(best_r_reg);
            out_col_reg    <= 4'(best_c_reg);
            out_regret_reg <= 17'(best_regret_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign best_row  = out_row_reg;
    assign best_col  = out_col_reg;
    assign regret    = out_regret_reg;

    // ---------------- assertions ----------------
    a_regret_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (regret <= 17'(ONE_FX)))
        else $error("reported regret exceeds one");

    a_default_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (regret == 17'(ONE_FX))) |-> (best_row == '0 && best_col == '0))
        else $error("regret of one reported for a cell other than the first");

    a_regret_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (state_reg == ST_PASS2 || state_reg == ST_DRAIN))
        else $error("regret stage active outside the second pass");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (({1'b0, best_row} < 5'(rows_eff)) && ({1'b0, best_col} < 5'(cols_eff))))
        else $error("reported cell lies outside the dimensions in use");

endmodule

### tb/pens_search_checker.sv
// Checker for the pure-strategy epsilon-Nash search block: watches both item channels and
// the register port, predicts each search result and compares it field by field.
// Depends on pens_pkg for widths, register and function codes.
`timescale 1ns / 100ps

module pens_search_checker
    import pens_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                func,
    input  logic [3:0]          row_index,
    input  logic [3:0]          col_index,
    input  logic [16:0]         row_payoff,
    input  logic [16:0]         col_payoff,

    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [3:0]          best_row,
    input  logic [3:0]          best_col,
    input  logic [16:0]         regret,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,

    input  logic                run_done,
    output int                  pending_results,
    output int                  results_checked,
    output int                  fail_count
);

    typedef struct packed {
        logic [ROW_W-1:0] best_row;
        logic [COL_W-1:0] best_col;
        logic [PAY_W-1:0] regret;
    } profile_t;

    logic [PAY_W-1:0] row_table [CELLS];
    logic [PAY_W-1:0] col_table [CELLS];
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    profile_t         expected_profiles [$];
    int               mismatches = 0;
    int               checked = 0;
    bit               leftovers_done = 1'b0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // A dimension register of zero means one strategy; values past the table are cut down.
    function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] raw,
                                               input int unsigned limit);
        if (raw == 0)
            return 1;
        if (raw > limit)
            return limit;
        return raw;
    endfunction

    function automatic profile_t least_regret_profile();
        int unsigned rows, cols, own_r, own_c, v, worst, lowest;
        int          r, c, k;
        profile_t    p;

        rows   = dim_in_use(rows_reg, MAX_ROWS);
        cols   = dim_in_use(cols_reg, MAX_COLS);
        lowest = ONE_FX;
        p      = '{best_row: '0, best_col: '0, regret: ONE_FX};
        for (r = 0; r < rows; r++)
        begin
            for (c = 0; c < cols; c++)
            begin
                own_r = row_table[r * MAX_COLS + c];
                own_c = col_table[r * MAX_COLS + c];
                worst = 0;
                for (k = 0; k < rows; k++)
                begin
                    v = row_table[k * MAX_COLS + c];
                    if (v > own_r && v - own_r > worst)
                        worst = v - own_r;
                end
                for (k = 0; k < cols; k++)
                begin
                    v = col_table[r * MAX_COLS + k];
                    if (v > own_c && v - own_c > worst)
                        worst = v - own_c;
                end
                // Only a strictly smaller regret displaces the earlier cell.
                if (worst < lowest)
                begin
                    lowest     = worst;
                    p.best_row = ROW_W'(r);
                    p.best_col = COL_W'(c);
                    p.regret   = PAY_W'(worst);
                end
            end
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        profile_t want;

        if (!rst_n)
        begin
            rows_reg = DIM_W'(1);
            cols_reg = DIM_W'(1);
            expected_profiles.delete();
            pending_results <= 0;
            results_checked <= 0;
            fail_count      <= mismatches;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_NUM_COLS)
                    cols_reg = pwdata[DIM_W-1:0];
                else
                    rows_reg = pwdata[DIM_W-1:0];
            end

            if (out_valid && !out_stall)
            begin
                if (expected_profiles.size() == 0)
                    report_mismatch("result item arrived with no search waiting for it");
                else
                begin
                    want = expected_profiles.pop_front();
                    checked++;
                    if (best_row !== want.best_row)
                        report_mismatch($sformatf("best_row %0d, expected %0d",
                                                  best_row, want.best_row));
                    if (best_col !== want.best_col)
                        report_mismatch($sformatf("best_col %0d, expected %0d",
                                                  best_col, want.best_col));
                    if (regret !== want.regret)
                        report_mismatch($sformatf("regret 0x%05h, expected 0x%05h",
                                                  regret, want.regret));
                end
            end

            if (in_valid && !in_stall)
            begin
                if (func == FUNC_SEARCH)
                    expected_profiles.push_back(least_regret_profile());
                else
                begin
                    row_table[row_index * MAX_COLS + col_index] = row_payoff;
                    col_table[row_index * MAX_COLS + col_index] = col_payoff;
                end
            end

            if (run_done && !leftovers_done)
            begin
                leftovers_done = 1'b1;
                if (expected_profiles.size() != 0)
                    report_mismatch($sformatf("%0d expected results never came out",
                                              expected_profiles.size()));
            end

            pending_results <= expected_profiles.size();
            results_checked <= checked;
            fail_count      <= mismatches;
        end
    end

endmodule

### tb/pure_epsilon_nash_search_tb.sv
// Top of the testbench for pure_epsilon_nash_search: clock, reset, register writes and
// item stimulus with random idling on both sides, plus the final verdict.
// Depends on pens_pkg, the block itself and pens_search_checker.
`timescale 1ns / 100ps

module pure_epsilon_nash_search_tb;
    import pens_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                func = FUNC_LOAD;
    logic [3:0]          row_index = '0;
    logic [3:0]          col_index = '0;
    logic [16:0]         row_payoff = '0;
    logic [16:0]         col_payoff = '0;

    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [3:0]          best_row;
    logic [3:0]          best_col;
    logic [16:0]         regret;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    logic                run_done = 1'b0;
    logic                pressure_go = 1'b0;
    int                  pending_results;
    int                  results_checked;
    int                  fail_count;

    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  n_loads = 0;
    int                  n_searches = 0;
    int                  n_settings = 0;
    int unsigned         rows_used = 1;
    int unsigned         cols_used = 1;
    bit                  cell_loaded [CELLS];

    localparam logic [PAY_W-1:0] QUARTER = ONE_FX >> 2;

    pure_epsilon_nash_search i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .row_index  (row_index),
        .col_index  (col_index),
        .row_payoff (row_payoff),
        .col_payoff (col_payoff),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .best_row   (best_row),
        .best_col   (best_col),
        .regret     (regret),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    pens_search_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .row_index       (row_index),
        .col_index       (col_index),
        .row_payoff      (row_payoff),
        .col_payoff      (col_payoff),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .best_row        (best_row),
        .best_col        (best_col),
        .regret          (regret),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .run_done        (run_done),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .fail_count      (fail_count)
    );

    always #10 clk = ~clk;

    initial
    begin
        #200ms;
        $display("FAIL");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off that lets the block back up.
    initial
    begin : receiver
        int hold_left;
        bit hold_used;

        hold_left = 0;
        hold_used = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_go && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = 1500;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Quarter steps give ties and zero gaps; a share of values lies above one.
    function automatic logic [PAY_W-1:0] pick_payoff();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ONE_FX;
            2:       return PAY_W'(ONE_FX + $urandom_range(1, 65535));
            3, 4, 5: return PAY_W'($urandom_range(4) * QUARTER);
            default: return PAY_W'($urandom_range(ONE_FX));
        endcase
    endfunction

    task automatic send_item(input logic f, input logic [3:0] ri, input logic [3:0] ci,
                             input logic [PAY_W-1:0] rp, input logic [PAY_W-1:0] cp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        row_index  <= ri;
        col_index  <= ci;
        row_payoff <= rp;
        col_payoff <= cp;
        do
            @(posedge clk);
        while (in_stall);
        if (f == FUNC_SEARCH)
            n_searches++;
        else
            n_loads++;
    endtask

    task automatic load_cell(input int unsigned r, input int unsigned c,
                             input logic [PAY_W-1:0] rp, input logic [PAY_W-1:0] cp);
        send_item(FUNC_LOAD, 4'(r), 4'(c), rp, cp);
        cell_loaded[r * MAX_COLS + c] = 1'b1;
    endtask

    // Cells in use that were never loaded would be read by a search, so load them first.
    task automatic search_game();
        int unsigned r, c;

        for (r = 0; r < rows_used; r++)
            for (c = 0; c < cols_used; c++)
                if (!cell_loaded[r * MAX_COLS + c])
                    load_cell(r, c, pick_payoff(), pick_payoff());
        send_item(FUNC_SEARCH, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  pick_payoff(), pick_payoff());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [DIM_W-1:0] value);
        logic [APB_DW-1:0] data;

        data = $urandom();
        data[DIM_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_dims(input int unsigned rows_raw, input int unsigned cols_raw);
        wait_idle();
        write_reg(REG_NUM_ROWS, DIM_W'(rows_raw));
        write_reg(REG_NUM_COLS, DIM_W'(cols_raw));
        rows_used = (rows_raw == 0) ? 1 : (rows_raw > MAX_ROWS) ? MAX_ROWS : rows_raw;
        cols_used = (cols_raw == 0) ? 1 : (cols_raw > MAX_COLS) ? MAX_COLS : cols_raw;
        n_settings++;
    endtask

    // Mostly a few loads inside the game followed by a search; sometimes searches back
    // to back, sometimes loads anywhere in the table.
    task automatic game_round();
        int unsigned kind, span;

        kind = $urandom_range(99);
        span = rows_used * cols_used;
        if (kind < 75)
        begin
            repeat ($urandom_range(1, (span < 10) ? span : 10))
                load_cell($urandom_range(rows_used - 1), $urandom_range(cols_used - 1),
                          pick_payoff(), pick_payoff());
            search_game();
        end
        else if (kind < 85)
        begin
            search_game();
            search_game();
        end
        else
            repeat ($urandom_range(1, 4))
                load_cell($urandom_range(MAX_ROWS - 1), $urandom_range(MAX_COLS - 1),
                          pick_payoff(), pick_payoff());
    endtask

    initial
    begin : stimulus
        int phase, seg, start;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One cell under the reset dimensions.
        load_cell(0, 0, ONE_FX, ONE_FX);
        search_game();
        set_dims(2, 2);
        // Matching pennies at the payoff extremes: no cell gets below one.
        load_cell(0, 0, ONE_FX, '0);
        load_cell(0, 1, '0, ONE_FX);
        load_cell(1, 0, '0, ONE_FX);
        load_cell(1, 1, ONE_FX, '0);
        search_game();
        load_cell(1, 1, '1, '1);
        search_game();
        // Equal payoffs tie at zero regret, and the first cell in row-major order wins.
        load_cell(0, 0, QUARTER, QUARTER);
        load_cell(0, 1, QUARTER, QUARTER);
        load_cell(1, 0, QUARTER, QUARTER);
        load_cell(1, 1, QUARTER, QUARTER);
        search_game();
        load_cell(0, 0, '0, '0);
        search_game();
        search_game();
        search_game();
        set_dims(0, 0);
        search_game();

        for (phase = 0; phase < 3; phase++)
        begin
            wait_idle();
            send_idle_pct <= (phase == 0) ? 38 : (phase == 1) ? 49 : 0;
            recv_idle_pct <= (phase == 0) ? 49 : (phase == 1) ? 38 : 0;
            for (seg = 0; seg < 6; seg++)
            begin
                case (seg)
                    0: set_dims($urandom_range(1, 3), $urandom_range(1, 3));
                    1: set_dims($urandom_range(1), 1);
                    2: set_dims(MAX_ROWS, MAX_COLS);
                    3: set_dims($urandom_range(1), $urandom_range(17, 31));
                    4: set_dims($urandom_range(17, 31), $urandom_range(1));
                    default: set_dims($urandom_range(1, 6), $urandom_range(1, 6));
                endcase
                if (phase == 2 && seg == 0)
                    pressure_go <= 1'b1;
                start = n_loads + n_searches;
                while (n_loads + n_searches - start < 80)
                    game_round();
            end
        end

        wait_idle();
        repeat (30) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Sent %0d loads and %0d searches over %0d dimension settings;",
                 n_loads, n_searches, n_settings);
        $display("checked %0d results with idling on both sides and one long output hold.",
                 results_checked);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/pens_pkg.sv
rtl/core/pens_ram.sv
rtl/core/pure_epsilon_nash_search.sv
tb/pens_search_checker.sv
tb/pure_epsilon_nash_search_tb.sv
